@@ hw/rtl/fst_pkg.sv @@
package fst_pkg;

    localparam int PHASE_W   = 32;
    localparam int AMP_W     = 15;
    localparam int ENV_W     = 31;
    localparam int LEN_W     = 24;
    localparam int MAG_W     = 15;
    localparam int SMP_W     = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LEN   = 3'd4;

    localparam logic [63:0] PI_Q32  = 64'd13493037705;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef enum logic [1:0] {
        SEG_FADE_IN  = 2'd0,
        SEG_HOLD     = 2'd1,
        SEG_FADE_OUT = 2'd2,
        SEG_DONE     = 2'd3
    } t_seg;

    typedef struct packed {
        logic [ENV_W-1:0] env;
        logic             neg;
        t_seg             seg;
        logic             last;
    } t_s1;

    // quarter-wave entry: Q30 Horner series, products truncated, final scaling rounded
    function automatic logic [MAG_W-1:0] sine_entry(input int idx, input int tab_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] p;
        logic [63:0] s;
        x  = (64'(2 * idx + 1) * PI_Q32) >> (tab_bits + 4);
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        for (int k = 0; k < 5; k++) begin
            p = (x2 * t) >> 30;
            case (k)
                0:       p = p / 64'd110;
                1:       p = p / 64'd72;
                2:       p = p / 64'd42;
                3:       p = p / 64'd20;
                default: p = p / 64'd6;
            endcase
            t = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        end
        s = (x * t) >> 30;
        s = (s * 64'd32767 + 64'd536870912) >> 30;
        if (s > 64'd32767) s = 64'd32767;
        return s[MAG_W-1:0];
    endfunction

endpackage

@@ hw/rtl/fst_sine_rom.sv @@
module fst_sine_rom #(
    parameter int TABLE_BITS = 10
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [TABLE_BITS-1:0]   i_addr,
    output logic [fst_pkg::MAG_W-1:0] o_data
);
    import fst_pkg::*;

    localparam int TAB_SIZE = 1 << TABLE_BITS;

    logic [MAG_W-1:0] rom [TAB_SIZE];
    logic [MAG_W-1:0] r_data;

    for (genvar g = 0; g < TAB_SIZE; g++) begin : g_rom
        assign rom[g] = sine_entry(g, TABLE_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= rom[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

@@ hw/rtl/fst_ctrl.sv @@
module fst_ctrl #(
    parameter int TABLE_BITS = 10,
    parameter int COUNT_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_restart,
    input  logic [fst_pkg::PHASE_W-1:0] i_phase_step,
    input  logic [fst_pkg::AMP_W-1:0]   i_amplitude,
    input  logic [fst_pkg::ENV_W-1:0]   i_amp_step,
    input  logic [fst_pkg::LEN_W-1:0]   i_fade_samples,
    input  logic [fst_pkg::LEN_W-1:0]   i_hold_samples,
    output logic [TABLE_BITS-1:0]       o_rom_addr,
    output fst_pkg::t_s1                o_s1
);
    import fst_pkg::*;

    localparam int LW = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

    function automatic logic [COUNT_BITS-1:0] limit_of(input logic [LEN_W-1:0] len);
        logic [LW-1:0] w;
        logic [LW-1:0] cmax;
        w    = LW'(len);
        cmax = LW'({COUNT_BITS{1'b1}});
        if (w == '0) w = LW'(1);
        if (w > cmax) w = cmax;
        return COUNT_BITS'(w);
    endfunction

    logic [PHASE_W-1:0]    r_phase, n_phase;
    logic [ENV_W-1:0]      r_env, n_env;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    t_seg                  r_seg, n_seg;
    t_s1                   r_s1, n_s1;

    logic [PHASE_W-1:0]    ph;
    logic [ENV_W-1:0]      env;
    logic [COUNT_BITS-1:0] cnt;
    t_seg                  seg;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [COUNT_BITS-1:0] lim_fade;
    logic [COUNT_BITS-1:0] lim_hold;
    logic [ENV_W:0]        env_sum;
    logic [ENV_W-1:0]      env_up;
    logic [ENV_W-1:0]      env_down;
    logic [ENV_W-1:0]      env_full;
    logic [TABLE_BITS-1:0] addr;

    assign ph  = i_restart ? '0 : r_phase;
    assign env = i_restart ? '0 : r_env;
    assign cnt = i_restart ? '0 : r_cnt;
    assign seg = i_restart ? SEG_FADE_IN : r_seg;

    assign cnt_inc  = cnt + COUNT_BITS'(1);
    assign lim_fade = limit_of(i_fade_samples);
    assign lim_hold = limit_of(i_hold_samples);
    assign env_sum  = {1'b0, env} + {1'b0, i_amp_step};
    assign env_up   = env_sum[ENV_W] ? '1 : env_sum[ENV_W-1:0];
    assign env_down = (i_amp_step > env) ? '0 : env - i_amp_step;
    assign env_full = {i_amplitude, 16'd0};

    // quadrants 1 and 3 read the table mirrored
    assign addr       = ph[PHASE_W-3 -: TABLE_BITS];
    assign o_rom_addr = ph[PHASE_W-2] ? ~addr : addr;

    always_comb begin
        n_phase     = ph + i_phase_step;
        n_env       = env;
        n_cnt       = cnt_inc;
        n_seg       = seg;
        n_s1.env    = env;
        n_s1.neg    = ph[PHASE_W-1];
        n_s1.seg    = seg;
        n_s1.last   = 1'b0;
        case (seg)
            SEG_FADE_IN: begin
                if (cnt_inc >= lim_fade) begin
                    n_seg = SEG_HOLD;
                    n_cnt = '0;
                    n_env = env_full;
                end else begin
                    n_env = env_up;
                end
            end
            SEG_HOLD: begin
                n_env = env_full;
                if (cnt_inc >= lim_hold) begin
                    n_seg = SEG_FADE_OUT;
                    n_cnt = '0;
                end
            end
            SEG_FADE_OUT: begin
                if (cnt_inc >= lim_fade) begin
                    n_s1.last = 1'b1;
                    n_seg     = SEG_DONE;
                    n_cnt     = '0;
                    n_env     = '0;
                end else begin
                    n_env = env_down;
                end
            end
            default: begin
                n_phase  = ph;
                n_cnt    = cnt;
                n_s1.env = '0;
                n_s1.neg = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_env   <= '0;
            r_cnt   <= '0;
            r_seg   <= SEG_DONE;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_env   <= n_env;
            r_cnt   <= n_cnt;
            r_seg   <= n_seg;
            r_s1    <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

@@ hw/rtl/fst_scale.sv @@
module fst_scale (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  fst_pkg::t_s1                    i_s1,
    input  logic [fst_pkg::MAG_W-1:0]       i_mag,
    output logic signed [fst_pkg::SMP_W-1:0] o_sample,
    output logic [1:0]                      o_segment,
    output logic                            o_last
);
    import fst_pkg::*;

    localparam int PROD_W = ENV_W + MAG_W;

    logic [PROD_W-1:0]  prod;
    logic [PROD_W:0]    rnd;
    logic [SMP_W-1:0]   mag;
    logic [SMP_W-1:0]   n_sample;

    logic [SMP_W-1:0]   r_sample;
    logic [1:0]         r_segment;
    logic               r_last;

    assign prod     = PROD_W'(i_s1.env) * PROD_W'(i_mag);
    assign rnd      = {1'b0, prod} + (PROD_W + 1)'(64'd1 << 30);
    assign mag      = rnd[PROD_W -: SMP_W];
    assign n_sample = i_s1.neg ? SMP_W'(0) - mag : mag;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sample  <= n_sample;
            r_segment <= i_s1.seg;
            r_last    <= i_s1.last;
        end
    end

    assign o_sample  = signed'(r_sample);
    assign o_segment = r_segment;
    assign o_last    = r_last;

endmodule

@@ hw/rtl/faded_sine_trajectory_generator_core.sv @@
// Sine generator with a linear fade-in / hold / fade-out envelope. Each input
// transaction (restart or next-sample request) yields exactly one output
// transaction: sample, segment code and a last flag on the final fade-out
// sample. Throughput is one transaction per clock unless the output stalls; the
// result passes two registered stages, the quarter-wave table read alongside the
// trajectory state update, then the envelope multiply and rounding into the
// output register. Stalls on the output side back up through the two stages.
// The user must write configuration registers only while no transaction is in
// flight (the block does not enforce this); writes apply to the next request.
module faded_sine_trajectory_generator_core #(
    parameter int TABLE_BITS = 10,
    parameter int COUNT_BITS = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_restart,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [fst_pkg::SMP_W-1:0]   o_sample,
    output logic [1:0]                         o_segment,
    output logic                               o_last,
    input  logic                               i_cfg_wr_en,
    input  logic [fst_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fst_pkg::CFG_W-1:0]          i_cfg_wdata
);
    import fst_pkg::*;

    logic [PHASE_W-1:0] r_phase_step;
    logic [AMP_W-1:0]   r_amplitude;
    logic [ENV_W-1:0]   r_amp_step;
    logic [LEN_W-1:0]   r_fade_samples;
    logic [LEN_W-1:0]   r_hold_samples;

    logic r_s1_valid;
    logic r_out_valid;
    logic out_ready;
    logic s1_ready;
    logic accept;
    logic s1_adv;

    logic [TABLE_BITS-1:0] rom_addr;
    logic [MAG_W-1:0]      rom_data;
    t_s1                   s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step   <= '0;
            r_amplitude    <= '0;
            r_amp_step     <= '0;
            r_fade_samples <= LEN_W'(1);
            r_hold_samples <= LEN_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PHASE_STEP: r_phase_step   <= i_cfg_wdata[PHASE_W-1:0];
                CFG_AMPLITUDE:  r_amplitude    <= i_cfg_wdata[AMP_W-1:0];
                CFG_AMP_STEP:   r_amp_step     <= i_cfg_wdata[ENV_W-1:0];
                CFG_FADE_LEN:   r_fade_samples <= i_cfg_wdata[LEN_W-1:0];
                CFG_HOLD_LEN:   r_hold_samples <= i_cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s1_ready   = !r_s1_valid || out_ready;
    assign accept     = i_in_valid && s1_ready;
    assign s1_adv     = r_s1_valid && out_ready;
    assign o_in_stall = !s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (out_ready) begin
                r_s1_valid <= 1'b0;
            end
            if (out_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    fst_ctrl #(
        .TABLE_BITS (TABLE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (accept),
        .i_restart      (i_restart),
        .i_phase_step   (r_phase_step),
        .i_amplitude    (r_amplitude),
        .i_amp_step     (r_amp_step),
        .i_fade_samples (r_fade_samples),
        .i_hold_samples (r_hold_samples),
        .o_rom_addr     (rom_addr),
        .o_s1           (s1)
    );

    fst_sine_rom #(
        .TABLE_BITS (TABLE_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (accept),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    fst_scale u_scale (
        .i_clk     (i_clk),
        .i_en      (s1_adv),
        .i_s1      (s1),
        .i_mag     (rom_data),
        .o_sample  (o_sample),
        .o_segment (o_segment),
        .o_last    (o_last)
    );

endmodule

@@ hw/rtl/fst_checker.sv @@
module fst_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic signed [fst_pkg::SMP_W-1:0]   o_sample,
    input logic [1:0]                         o_segment,
    input logic                               o_last
);
    import fst_pkg::*;

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_payload_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_sample) && $stable(o_segment) && $stable(o_last))
        else $error("stalled output transaction changed");

    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_segment == SEG_DONE |-> o_sample == '0 && !o_last)
        else $error("finished transaction carries a sample or last flag");

    a_last_in_fade_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_segment == SEG_FADE_OUT)
        else $error("last flag outside fade-out");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind faded_sine_trajectory_generator_core fst_checker u_fst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_sample    (o_sample),
    .o_segment   (o_segment),
    .o_last      (o_last)
);

@@ verif/fst_sample_checker.sv @@
module fst_sample_checker #(
    parameter int TABLE_BITS = 10,
    parameter int COUNT_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_restart,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [fst_pkg::SMP_W-1:0]     i_sample,
    input  logic [1:0]                    i_segment,
    input  logic                          i_last,
    input  logic                          i_cfg_wr_en,
    input  logic [fst_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fst_pkg::CFG_W-1:0]     i_cfg_wdata,
    output int                            o_mismatches,
    output int                            o_outstanding
);
    import fst_pkg::*;

    localparam int TAB_SIZE = 1 << TABLE_BITS;
    localparam logic [ENV_W-1:0] ENV_FULL = '1;

    typedef struct packed {
        logic [SMP_W-1:0] sample;
        t_seg             seg;
        logic             last;
    } t_fst_sample;

    logic [MAG_W-1:0]      sine_quarter [TAB_SIZE];

    logic [PHASE_W-1:0]    cfg_phase_step;
    logic [AMP_W-1:0]      cfg_amplitude;
    logic [ENV_W-1:0]      cfg_amp_step;
    logic [LEN_W-1:0]      cfg_fade;
    logic [LEN_W-1:0]      cfg_hold;

    logic [PHASE_W-1:0]    phase_acc;
    logic [ENV_W-1:0]      envelope;
    logic [COUNT_BITS-1:0] seg_count;
    t_seg                  seg_state;

    t_fst_sample           expected_samples [$];
    int                    mismatches;
    int                    outstanding;

    assign o_mismatches  = mismatches;
    assign o_outstanding = outstanding;

    // Q30 odd-power series, evaluated at the center of each table slot
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k);
        logic [63:0] ang;
        logic [63:0] ang_sq;
        logic [63:0] series;
        logic [63:0] part;
        logic [63:0] mag;
        ang    = (64'(2 * k + 1) * PI_Q32) >> (TABLE_BITS + 4);
        ang_sq = (ang * ang) >> 30;
        series = ONE_Q30;
        for (int j = 5; j >= 1; j--) begin
            part   = ((ang_sq * series) >> 30) / 64'(2 * j * (2 * j + 1));
            series = (part >= ONE_Q30) ? 64'd0 : ONE_Q30 - part;
        end
        mag = (ang * series) >> 30;
        mag = (mag * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
        if (mag > 64'd32767) mag = 64'd32767;
        return mag[MAG_W-1:0];
    endfunction

    function automatic longint unsigned seg_span(input logic [LEN_W-1:0] len);
        longint unsigned cap;
        cap = (64'd1 << COUNT_BITS) - 1;
        if (len == '0) return 1;
        if (64'(len) > cap) return cap;
        return 64'(len);
    endfunction

    function automatic t_fst_sample predict_sample(input logic restart);
        t_fst_sample           res;
        logic [1:0]            quad;
        logic [TABLE_BITS-1:0] idx;
        logic [63:0]           prod;
        logic [63:0]           rounded;
        logic [SMP_W-1:0]      smp;
        logic [COUNT_BITS-1:0] nxt;
        logic [31:0]           sum;
        if (restart) begin
            phase_acc = '0;
            envelope  = '0;
            seg_count = '0;
            seg_state = SEG_FADE_IN;
        end
        res.sample = '0;
        res.seg    = SEG_DONE;
        res.last   = 1'b0;
        if (seg_state == SEG_DONE) return res;

        quad = phase_acc[31:30];
        idx  = phase_acc[29 -: TABLE_BITS];
        if (quad[0]) idx = ~idx;
        prod    = 64'(envelope) * 64'(sine_quarter[idx]);
        rounded = (prod + (64'd1 << 30)) >> 31;
        smp     = rounded[SMP_W-1:0];
        if (quad[1]) smp = -smp;
        res.sample = smp;
        res.seg    = seg_state;

        nxt = seg_count + 1'b1;
        case (seg_state)
            SEG_FADE_IN: begin
                if (64'(nxt) >= seg_span(cfg_fade)) begin
                    seg_state = SEG_HOLD;
                    nxt       = '0;
                    envelope  = {cfg_amplitude, 16'b0};
                end else begin
                    sum      = 32'(envelope) + 32'(cfg_amp_step);
                    envelope = sum[31] ? ENV_FULL : sum[ENV_W-1:0];
                end
            end
            SEG_HOLD: begin
                envelope = {cfg_amplitude, 16'b0};
                if (64'(nxt) >= seg_span(cfg_hold)) begin
                    seg_state = SEG_FADE_OUT;
                    nxt       = '0;
                end
            end
            default: begin
                if (64'(nxt) >= seg_span(cfg_fade)) begin
                    res.last  = 1'b1;
                    seg_state = SEG_DONE;
                    nxt       = '0;
                    envelope  = '0;
                end else begin
                    envelope = (cfg_amp_step > envelope) ? '0 : envelope - cfg_amp_step;
                end
            end
        endcase
        seg_count = nxt;
        phase_acc = phase_acc + cfg_phase_step;
        return res;
    endfunction

    initial begin
        mismatches  = 0;
        outstanding = 0;
        for (int k = 0; k < TAB_SIZE; k++) sine_quarter[k] = quarter_sine(k);
    end

    always @(posedge i_clk) begin
        t_fst_sample exp_s;
        if (!i_rst_n) begin
            cfg_phase_step = '0;
            cfg_amplitude  = '0;
            cfg_amp_step   = '0;
            cfg_fade       = LEN_W'(1);
            cfg_hold       = LEN_W'(1);
            phase_acc      = '0;
            envelope       = '0;
            seg_count      = '0;
            seg_state      = SEG_DONE;
            expected_samples.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_PHASE_STEP: cfg_phase_step = i_cfg_wdata[PHASE_W-1:0];
                    CFG_AMPLITUDE:  cfg_amplitude  = i_cfg_wdata[AMP_W-1:0];
                    CFG_AMP_STEP:   cfg_amp_step   = i_cfg_wdata[ENV_W-1:0];
                    CFG_FADE_LEN:   cfg_fade       = i_cfg_wdata[LEN_W-1:0];
                    CFG_HOLD_LEN:   cfg_hold       = i_cfg_wdata[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_samples.size() == 0) begin
                    $error("unexpected output transaction: sample %0d segment %0d last %0b",
                           $signed(i_sample), i_segment, i_last);
                    mismatches++;
                end else begin
                    exp_s = expected_samples.pop_front();
                    if (exp_s.sample !== i_sample) begin
                        $error("sample: expected %0d, got %0d",
                               $signed(exp_s.sample), $signed(i_sample));
                        mismatches++;
                    end
                    if (exp_s.seg !== i_segment) begin
                        $error("segment: expected %0d, got %0d", exp_s.seg, i_segment);
                        mismatches++;
                    end
                    if (exp_s.last !== i_last) begin
                        $error("last: expected %0b, got %0b", exp_s.last, i_last);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                exp_s = predict_sample(i_restart);
                expected_samples.insert(expected_samples.size(), exp_s);
            end
        end
        outstanding = expected_samples.size();
    end

endmodule

@@ verif/tb_faded_sine_trajectory_generator_core.sv @@
module tb_faded_sine_trajectory_generator_core;
    import fst_pkg::*;

    localparam int ITEMS      = 1650;
    localparam int WATCHDOG   = 5000;
    localparam int HOLDOFF    = 80;
    localparam int MAX_TRAJ   = 60;
    localparam int LEN_MAX    = 16777215;
    localparam int AMP_STEP_MAX = 2147418112;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_restart;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [SMP_W-1:0]     o_sample;
    logic [1:0]           o_segment;
    logic                 o_last;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_wdata;

    int                   mismatches;
    int                   outstanding;
    int                   samples_sent = 0;
    int                   idle_cycles = 0;
    logic                 holdoff_done = 1'b0;
    logic                 quiet;

    int unsigned          cur_amp;
    int unsigned          cur_fade;
    int unsigned          cur_hold;

    assign quiet = (samples_sent >= 900) && (samples_sent < 1150);

    always #6 i_clk = ~i_clk;

    faded_sine_trajectory_generator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample    (o_sample),
        .o_segment   (o_segment),
        .o_last      (o_last),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    fst_sample_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_restart     (i_restart),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_sample      (o_sample),
        .i_segment     (o_segment),
        .i_last        (o_last),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    task automatic send_item(input logic restart);
        while (!quiet && ($urandom_range(99) < 23)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        do @(posedge i_clk); while (o_in_stall);
        samples_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // receiver
    initial begin
        forever begin
            @(negedge i_clk);
            if (!holdoff_done && samples_sent >= 350) begin
                holdoff_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLDOFF) @(negedge i_clk);
            end else begin
                i_out_stall <= !quiet && ($urandom_range(99) < 23);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG) begin
                $display("Mismatches found");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int unsigned fe;
        int unsigned he;
        int unsigned span;
        int unsigned sel;
        int unsigned n_traj;
        logic [CFG_W-1:0] val;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_restart   = 1'b0;
        i_out_stall = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        cur_amp     = 0;
        cur_fade    = 1;
        cur_hold    = 1;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: finished, then a minimal silent trajectory
        send_item(1'b0);
        send_item(1'b1);
        repeat (3) send_item(1'b0);

        // quarter-turn phase, full amplitude, envelope saturating both ways
        wait_drained();
        write_reg(CFG_PHASE_STEP, 32'h4000_0000);
        write_reg(CFG_AMPLITUDE, 32'd32767);
        write_reg(CFG_AMP_STEP, AMP_STEP_MAX);
        write_reg(CFG_FADE_LEN, 32'd3);
        write_reg(CFG_HOLD_LEN, 32'd2);
        i_cfg_wr_en <= 1'b0;
        send_item(1'b1);
        repeat (8) send_item(1'b0);

        // zero lengths, restart mid-trajectory
        wait_drained();
        write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
        write_reg(CFG_AMP_STEP, 32'd0);
        write_reg(CFG_FADE_LEN, 32'd0);
        write_reg(CFG_HOLD_LEN, 32'd0);
        i_cfg_wr_en <= 1'b0;
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b1);
        repeat (3) send_item(1'b0);

        // longest segments
        wait_drained();
        write_reg(CFG_AMP_STEP, 32'd1);
        write_reg(CFG_FADE_LEN, LEN_MAX);
        write_reg(CFG_HOLD_LEN, LEN_MAX);
        i_cfg_wr_en <= 1'b0;
        send_item(1'b1);
        repeat (3) send_item(1'b0);
        cur_amp  = 32767;
        cur_fade = LEN_MAX;
        cur_hold = LEN_MAX;

        while (samples_sent < ITEMS) begin
            wait_drained();
            if ($urandom_range(1)) begin
                case ($urandom_range(3))
                    0:       val = 32'd0;
                    1:       val = 32'hFFFF_FFFF;
                    default: val = $urandom;
                endcase
                write_reg(CFG_PHASE_STEP, val);
            end
            if ($urandom_range(1)) begin
                case ($urandom_range(3))
                    0:       cur_amp = 0;
                    1:       cur_amp = 32767;
                    default: cur_amp = $urandom_range(32767);
                endcase
                write_reg(CFG_AMPLITUDE, cur_amp);
            end
            if ($urandom_range(1)) begin
                case ($urandom_range(9))
                    0:       cur_fade = 0;
                    1:       cur_fade = LEN_MAX;
                    2:       cur_fade = $urandom_range(LEN_MAX, 1);
                    default: cur_fade = $urandom_range(10, 1);
                endcase
                write_reg(CFG_FADE_LEN, cur_fade);
            end
            if ($urandom_range(1)) begin
                case ($urandom_range(9))
                    0:       cur_hold = 0;
                    1:       cur_hold = LEN_MAX;
                    default: cur_hold = $urandom_range(10, 1);
                endcase
                write_reg(CFG_HOLD_LEN, cur_hold);
            end
            fe = (cur_fade == 0) ? 1 : cur_fade;
            he = (cur_hold == 0) ? 1 : cur_hold;
            if ($urandom_range(1)) begin
                case ($urandom_range(5))
                    0:       val = 32'd0;
                    1:       val = AMP_STEP_MAX;
                    2:       val = $urandom_range(AMP_STEP_MAX);
                    default: val = (cur_amp << 16) / fe;
                endcase
                write_reg(CFG_AMP_STEP, val);
            end
            i_cfg_wr_en <= 1'b0;

            span = 2 * fe + he;
            if (fe > MAX_TRAJ || he > MAX_TRAJ || span > MAX_TRAJ) span = MAX_TRAJ;
            n_traj = $urandom_range(4, 1);
            repeat (n_traj) begin
                sel = $urandom_range(99);
                if (sel < 10) begin
                    repeat ($urandom_range(8, 1)) send_item($urandom_range(1));
                end else if (sel < 20) begin
                    send_item(1'b1);
                    repeat ($urandom_range(span)) send_item(1'b0);
                end else begin
                    // sometimes carry on with the trajectory already running
                    if (sel >= 30) send_item(1'b1);
                    repeat (span - 1 + $urandom_range(3)) send_item(1'b0);
                end
            end
        end

        wait_drained();
        repeat (6) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/fst_pkg.sv
hw/rtl/fst_sine_rom.sv
hw/rtl/fst_ctrl.sv
hw/rtl/fst_scale.sv
hw/rtl/faded_sine_trajectory_generator_core.sv
hw/rtl/fst_checker.sv
verif/fst_sample_checker.sv
verif/tb_faded_sine_trajectory_generator_core.sv
